// ----- design/cossim_pkg.sv -----
// Shared types and widths for the cosine similarity core.
// Used by cosine_similarity_core and its bound checker; no dependencies.
package cossim_pkg;

  localparam int ELEM_W        = 16;  // port width of one vector element
  localparam int SIM_W         = 16;  // Q1.15 result width
  localparam int ELEM_BITS_DEF = 16;  // element bits taken from each port field

  localparam int DOT_W  = 42;              // signed dot product accumulator
  localparam int NORM_W = 41;              // unsigned squared-norm accumulators
  localparam int PROD_W = 2 * NORM_W;      // normA * normB
  localparam int ROOT_W = NORM_W;          // isqrt(normA * normB)
  localparam int REM_W  = ROOT_W + 3;      // square root partial remainder
  localparam int ALU_W  = PROD_W + 2;      // shared add / subtract unit
  localparam int Q_W    = SIM_W;           // quotient bits kept by the divider
  localparam int CNT_W  = $clog2(NORM_W);  // step counter

  localparam logic [Q_W-1:0] SIM_MAX = {1'b0, {(Q_W-1){1'b1}}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
    logic                     last;
  } elem_t;

  typedef struct packed {
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;
  } res_t;

endpackage

// ----- design/cosine_similarity_core.sv -----
// Streaming cosine similarity of two Q1.15 vectors with one shared multiplier
// and one shared wide add/subtract unit. Depends on cossim_pkg.
//
// Element pairs arrive on the elem channel, one item per pair, and the pair
// marked last closes the vector. Each pair occupies the block for its accept
// cycle plus three passes through the single element multiplier (a*b, a*a,
// b*b), each folded into a saturating accumulator. After the last pair the
// block works on its own before the result item is registered: a zero-norm
// check, a 41-step shift-add product normA*normB, a 41-step digit-by-digit
// square root and a 16-step restoring divide, all on the same 84-bit
// add/subtract unit. A vector with a zero norm skips straight from the check
// to the result. The result sits in an output register, so the next vector's
// pairs are taken while it waits; the block stalls only when a new result is
// ready and the previous one is still not taken.
// similarity = trunc(dot * 32768 / isqrt(normA * normB)), saturated to Q1.15;
// zero_norm flags a zero vector and forces similarity to 0.
module cosine_similarity_core #(
  parameter int ELEM_BITS = cossim_pkg::ELEM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               elem_valid,
  output logic               elem_ready,
  input  cossim_pkg::elem_t  elem,
  output logic               res_valid,
  input  logic               res_ready,
  output cossim_pkg::res_t   res
);

  localparam int DOT_W  = cossim_pkg::DOT_W;
  localparam int NORM_W = cossim_pkg::NORM_W;
  localparam int PROD_W = cossim_pkg::PROD_W;
  localparam int ROOT_W = cossim_pkg::ROOT_W;
  localparam int REM_W  = cossim_pkg::REM_W;
  localparam int ALU_W  = cossim_pkg::ALU_W;
  localparam int Q_W    = cossim_pkg::Q_W;
  localparam int CNT_W  = cossim_pkg::CNT_W;

  localparam int MUL_W  = 2 * ELEM_BITS;
  localparam int DSUM_W = ((MUL_W > DOT_W) ? MUL_W : DOT_W) + 1;
  localparam int NSUM_W = ((MUL_W > NORM_W) ? MUL_W : NORM_W) + 1;

  localparam logic [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // take the next pair
  localparam logic [2:0] S_MAC  = 3'd1;  // three multiply-accumulate passes
  localparam logic [2:0] S_CHK  = 3'd2;  // zero-norm check, set up product
  localparam logic [2:0] S_MULT = 3'd3;  // normA * normB, one bit of normB per cycle
  localparam logic [2:0] S_SQRT = 3'd4;  // square root, one root bit per cycle
  localparam logic [2:0] S_DCHK = 3'd5;  // quotient overflow check
  localparam logic [2:0] S_DIV  = 3'd6;  // restoring divide, one bit per cycle
  localparam logic [2:0] S_OUT  = 3'd7;  // hand result to the output register

  localparam logic [1:0] K_DOT = 2'd0;
  localparam logic [1:0] K_NA  = 2'd1;
  localparam logic [1:0] K_NB  = 2'd2;

  // control
  logic [2:0]       state;
  logic [1:0]       k;
  logic [CNT_W-1:0] cnt;
  logic             last_flag;

  // element operands and accumulators
  logic signed [ELEM_BITS-1:0] a_val;
  logic signed [ELEM_BITS-1:0] b_val;
  logic signed [DOT_W-1:0]     dot_acc;
  logic [NORM_W-1:0]           norm_a;
  logic [NORM_W-1:0]           norm_b;

  // end-of-vector datapath
  logic [PROD_W-1:0] wide_acc;   // product, then radicand shifted out two bits a step
  logic [NORM_W-1:0] nb_sh;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem;
  logic [DOT_W-1:0]  mag;
  logic              neg;
  logic [Q_W-1:0]    q;
  logic [Q_W-1:0]    nlow;       // low dividend bits still to bring down
  logic              res_sat;
  logic              res_zero;

  // ---------------------------------------------------------------------------
  // Element multiplier and saturating accumulate
  // ---------------------------------------------------------------------------
  logic signed [ELEM_BITS-1:0] mul_x;
  logic signed [ELEM_BITS-1:0] mul_y;
  logic signed [MUL_W-1:0]     mul_out;
  logic signed [DSUM_W-1:0]    dot_sum;
  logic [DSUM_W-DOT_W:0]       dot_hi;
  logic [DOT_W-1:0]            dot_next;
  logic [NORM_W-1:0]           norm_old;
  logic [NSUM_W-1:0]           norm_sum;
  logic [NORM_W-1:0]           norm_next;

  always_comb begin
    case (k)
      K_DOT: begin
        mul_x = a_val;
        mul_y = b_val;
      end
      K_NA: begin
        mul_x = a_val;
        mul_y = a_val;
      end
      default: begin
        mul_x = b_val;
        mul_y = b_val;
      end
    endcase
  end

  assign mul_out = mul_x * mul_y;

  assign dot_sum  = DSUM_W'(dot_acc) + DSUM_W'(mul_out);
  assign dot_hi   = dot_sum[DSUM_W-1:DOT_W-1];
  // clamp when the accumulator's sign bit and the bits above it disagree
  assign dot_next = ((&dot_hi) || !(|dot_hi)) ? dot_sum[DOT_W-1:0] :
                    (dot_sum[DSUM_W-1] ? DOT_MIN : DOT_MAX);

  assign norm_old  = (k == K_NA) ? norm_a : norm_b;
  assign norm_sum  = NSUM_W'(norm_old) + NSUM_W'($unsigned(mul_out));
  assign norm_next = (|norm_sum[NSUM_W-1:NORM_W]) ? {NORM_W{1'b1}} : norm_sum[NORM_W-1:0];

  // ---------------------------------------------------------------------------
  // Shared add / subtract unit: product, square root and divide steps
  // ---------------------------------------------------------------------------
  logic [ALU_W-1:0]  alu_x;
  logic [ALU_W-1:0]  alu_y;
  logic              alu_sub;
  logic [ALU_W:0]    alu_sum;
  logic [ALU_W-1:0]  alu_res;
  logic              alu_ge;
  logic [REM_W-1:0]  rem_sh;
  logic [ROOT_W:0]   div_sh;

  // bring down the next two radicand bits / the next dividend bit
  assign rem_sh = {rem[REM_W-3:0], wide_acc[PROD_W-1 -: 2]};
  assign div_sh = {rem[ROOT_W-1:0], nlow[Q_W-1]};

  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (state)
      S_MULT: begin
        alu_x = ALU_W'({wide_acc, 1'b0});
        alu_y = nb_sh[NORM_W-1] ? ALU_W'(norm_a) : '0;
      end
      S_SQRT: begin
        alu_x   = ALU_W'(rem_sh);
        alu_y   = ALU_W'({root, 2'b01});
        alu_sub = 1'b1;
      end
      S_DCHK: begin
        alu_x   = ALU_W'(mag[DOT_W-1:1]);
        alu_y   = ALU_W'(root);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_x   = ALU_W'(div_sh);
        alu_y   = ALU_W'(root);
        alu_sub = 1'b1;
      end
      default: begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + (ALU_W+1)'(alu_sub);
  assign alu_res = alu_sum[ALU_W-1:0];
  assign alu_ge  = alu_sum[ALU_W];  // carry out of a subtract: x >= y

  // ---------------------------------------------------------------------------
  // Result formatting and element sign handling
  // ---------------------------------------------------------------------------
  logic [DOT_W-1:0]           mag_in;
  logic [Q_W-1:0]             sim_fmt;
  logic [ELEM_BITS-1:0]       a_raw;
  logic [ELEM_BITS-1:0]       b_raw;

  assign mag_in = dot_acc[DOT_W-1] ? DOT_W'(unsigned'(-dot_acc)) : DOT_W'(unsigned'(dot_acc));

  always_comb begin
    if (res_zero) begin
      sim_fmt = '0;
    end else if (neg) begin
      sim_fmt = (res_sat || q[Q_W-1]) ? {1'b1, {(Q_W-1){1'b0}}} : (~q + 1'b1);
    end else begin
      sim_fmt = (res_sat || (q >= cossim_pkg::SIM_MAX)) ? cossim_pkg::SIM_MAX : q;
    end
  end

  // take the low ELEM_BITS bits of each field as two's complement
  assign a_raw = ELEM_BITS'($unsigned(elem.a_elem));
  assign b_raw = ELEM_BITS'($unsigned(elem.b_elem));

  assign elem_ready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= K_DOT;
      cnt       <= '0;
      last_flag <= 1'b0;
      dot_acc   <= '0;
      norm_a    <= '0;
      norm_b    <= '0;
      res_valid <= 1'b0;
    end else begin
      // drain the output register; in S_OUT the reload below owns res_valid
      if (res_valid && res_ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (elem_valid) begin
            a_val     <= a_raw;
            b_val     <= b_raw;
            last_flag <= elem.last;
            k         <= K_DOT;
            state     <= S_MAC;
          end
        end

        S_MAC: begin
          case (k)
            K_DOT: begin
              dot_acc <= dot_next;
              k       <= K_NA;
            end
            K_NA: begin
              norm_a <= norm_next;
              k      <= K_NB;
            end
            default: begin
              norm_b <= norm_next;
              k      <= K_DOT;
              state  <= last_flag ? S_CHK : S_IDLE;
            end
          endcase
        end

        S_CHK: begin
          res_sat <= 1'b0;
          neg     <= dot_acc[DOT_W-1];
          mag     <= mag_in;
          if ((norm_a == '0) || (norm_b == '0)) begin
            res_zero <= 1'b1;
            state    <= S_OUT;
          end else begin
            res_zero <= 1'b0;
            wide_acc <= '0;
            nb_sh    <= norm_b;
            cnt      <= CNT_W'(NORM_W - 1);
            state    <= S_MULT;
          end
        end

        S_MULT: begin
          wide_acc <= alu_res[PROD_W-1:0];
          nb_sh    <= {nb_sh[NORM_W-2:0], 1'b0};
          if (cnt == '0) begin
            rem   <= '0;
            root  <= '0;
            cnt   <= CNT_W'(ROOT_W - 1);
            state <= S_SQRT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_SQRT: begin
          wide_acc <= {wide_acc[PROD_W-3:0], 2'b00};
          if (alu_ge) begin
            rem  <= alu_res[REM_W-1:0];
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= S_DCHK;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_DCHK: begin
          // quotient of at least 2^16 saturates either way
          if (alu_ge) begin
            res_sat <= 1'b1;
            state   <= S_OUT;
          end else begin
            rem   <= REM_W'(mag[DOT_W-1:1]);
            q     <= '0;
            nlow  <= {mag[0], {(Q_W-1){1'b0}}};
            cnt   <= CNT_W'(Q_W - 1);
            state <= S_DIV;
          end
        end

        S_DIV: begin
          nlow <= {nlow[Q_W-2:0], 1'b0};
          if (alu_ge) begin
            rem <= REM_W'(alu_res[ROOT_W:0]);
            q   <= {q[Q_W-2:0], 1'b1};
          end else begin
            rem <= REM_W'(div_sh);
            q   <= {q[Q_W-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= S_OUT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end

        S_OUT: begin
          // hold until the output register is free, then clear for the next vector
          if (!res_valid || res_ready) begin
            res.similarity <= $signed(sim_fmt);
            res.zero_norm  <= res_zero;
            res_valid      <= 1'b1;
            dot_acc        <= '0;
            norm_a         <= '0;
            norm_b         <= '0;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/cossim_checker.sv -----
// Port-level checks for cosine_similarity_core, bound into every instance of it.
// Depends on cossim_pkg for the item types.
module cossim_checker (
  input logic               clk,
  input logic               rst,
  input logic               elem_valid,
  input logic               elem_ready,
  input cossim_pkg::elem_t  elem,
  input logic               res_valid,
  input logic               res_ready,
  input cossim_pkg::res_t   res
);

  // hold a stalled result item
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  // a zero-norm result carries a zero similarity
  a_zero_sim: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.zero_norm |-> res.similarity == '0)
    else $error("zero_norm result with nonzero similarity");

  // the shared multiplier is busy right after a pair is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    elem_valid && elem_ready |=> !elem_ready)
    else $error("pair accepted while multiplier busy");

  // a pair that does not close the vector frees the block after three passes
  a_mid_pair: assert property (@(posedge clk) disable iff (rst)
    elem_valid && elem_ready && !elem.last |-> ##4 elem_ready)
    else $error("block not ready after a mid-vector pair");

endmodule

bind cosine_similarity_core cossim_checker u_cossim_checker (.*);
